// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/psu_pkg.sv =====
// Package for the PNG scanline unfilter: filter codes, CSR indexes, widths,
// and the Paeth predictor. No dependencies.
`default_nettype none

package psu_pkg;

   localparam int DATA_W      = 8;
   localparam int BPP_W       = 4;
   localparam int ROW_BYTES_W = 13;
   localparam int CSR_DATA_W  = 13;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_kind_type;

   localparam logic [DATA_W-1:0] FILT_MAX_CODE = 8'h04;

   typedef enum logic [0:0] {
      CSR_BYTES_PER_PIXEL = 1'b0,
      CSR_ROW_BYTES       = 1'b1
   } csr_index_type;

   function automatic logic [DATA_W-1:0] paeth_pred(
      input logic [DATA_W-1:0] a,
      input logic [DATA_W-1:0] b,
      input logic [DATA_W-1:0] c
   );
      logic signed [DATA_W+1:0] pa_s;
      logic signed [DATA_W+1:0] pb_s;
      logic signed [DATA_W+1:0] pc_s;
      logic [DATA_W+1:0]        pa;
      logic [DATA_W+1:0]        pb;
      logic [DATA_W+1:0]        pc;
      logic [DATA_W-1:0]        res;
      // p - a = b - c, p - b = a - c, p - c = a + b - 2c
      pa_s = $signed({2'b00, b}) - $signed({2'b00, c});
      pb_s = $signed({2'b00, a}) - $signed({2'b00, c});
      pc_s = pa_s + pb_s;
      pa   = pa_s[DATA_W+1] ? (DATA_W+2)'(0) - pa_s : pa_s;
      pb   = pb_s[DATA_W+1] ? (DATA_W+2)'(0) - pb_s : pb_s;
      pc   = pc_s[DATA_W+1] ? (DATA_W+2)'(0) - pc_s : pc_s;
      if (pa <= pb && pa <= pc) begin
         res = a;
      end else if (pb <= pc) begin
         res = b;
      end else begin
         res = c;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/psu_if.sv =====
// Stream interfaces of the PNG scanline unfilter: request and response.
// Depends on psu_pkg.
`default_nettype none

interface psu_req_if;
   logic                        valid;
   logic                        ready;
   logic [psu_pkg::DATA_W-1:0]  data_byte;
   logic                        frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface psu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [psu_pkg::DATA_W-1:0]  pixel_byte;
   logic                        row_end;
   logic                        bad_filter;

   modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                   input ready);
   modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/png_scanline_unfilter.sv =====
// PNG scanline unfilter top level: None/Sub/Up/Average/Paeth reconstruction.
// Depends on psu_pkg, psu_if (psu_req_if, psu_rsp_if), psu_ram, assert_macros.svh.
//
//   channel   dir  payload                              handshake
//   req_chan  in   data_byte[7:0], frame_start          valid/ready
//   rsp_chan  out  pixel_byte[7:0], row_end, bad_filter valid/ready
//   csr_*     in   csr_index, csr_wdata[12:0]           csr_we, no stall
//
// One byte per cycle while rsp ready keeps up; each beat is reconstructed in its
// accept cycle. The byte above is prefetched from the line RAM when the preceding
// beat is accepted, so the registered RAM read adds no stall.
// Reset clears control state; the line RAM is not cleared (first row reads zero).
// req ready is held low only while a response is held and rsp ready is low.
`default_nettype none
`include "assert_macros.svh"

module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES       = 4096,
   parameter int MAX_BYTES_PER_PIXEL = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   psu_req_if.sink                              req_chan,
   psu_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire psu_pkg::csr_index_type          csr_index,
   input  wire logic [psu_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW   = $clog2(MAX_ROW_BYTES);
   localparam int CW   = $clog2(MAX_ROW_BYTES + 1);
   localparam int CMPW = (CW > psu_pkg::ROW_BYTES_W) ? CW : psu_pkg::ROW_BYTES_W;
   localparam int SW   = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
   localparam int DW   = psu_pkg::DATA_W;

   logic [psu_pkg::BPP_W-1:0]        bpp_ff, bpp_in;
   logic [psu_pkg::ROW_BYTES_W-1:0]  rb_ff, rb_in;
   logic [CW-1:0]                    col_ff, col_in;
   logic                             first_ff, first_in;
   psu_pkg::filter_kind_type         kind_ff, kind_in;
   logic [SW-1:0]                    cnt_ff [MAX_BYTES_PER_PIXEL];
   logic [SW-1:0]                    cnt_in [MAX_BYTES_PER_PIXEL];
   logic [DW-1:0]                    left_ff [MAX_BYTES_PER_PIXEL];
   logic [DW-1:0]                    left_in [MAX_BYTES_PER_PIXEL];
   logic [DW-1:0]                    ul_ff [MAX_BYTES_PER_PIXEL];
   logic [DW-1:0]                    ul_in [MAX_BYTES_PER_PIXEL];

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                    rsp_pixel_ff, rsp_pixel_in;
   logic                             rsp_end_ff, rsp_end_in;
   logic                             rsp_bad_ff, rsp_bad_in;

   logic                             accept;
   logic                             col_start;
   logic                             row_last;
   logic [SW-1:0]                    bpp_sel;
   logic [SW-1:0]                    slot;
   logic [CMPW-1:0]                  rb_eff;
   logic [AW-1:0]                    x_addr;
   logic [DW-1:0]                    a_byte, b_byte, c_byte, pred, val;
   logic [DW:0]                      avg_sum;

   logic                             ram_wr_en, ram_rd_en;
   logic [AW-1:0]                    ram_rd_addr;
   logic [DW-1:0]                    ram_rd_data;

   psu_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ROW_BYTES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (x_addr),
      .wr_data (val),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign col_start      = req_chan.frame_start || (col_ff == CW'(0));

   // effective config
   always_comb begin
      if (bpp_ff == psu_pkg::BPP_W'(0)) begin
         bpp_sel = SW'(0);
      end else if (bpp_ff > psu_pkg::BPP_W'(MAX_BYTES_PER_PIXEL)) begin
         bpp_sel = SW'(MAX_BYTES_PER_PIXEL - 1);
      end else begin
         bpp_sel = SW'(bpp_ff - psu_pkg::BPP_W'(1));
      end
      if (rb_ff == psu_pkg::ROW_BYTES_W'(0)) begin
         rb_eff = CMPW'(1);
      end else if (CMPW'(rb_ff) > CMPW'(MAX_ROW_BYTES)) begin
         rb_eff = CMPW'(MAX_ROW_BYTES);
      end else begin
         rb_eff = CMPW'(rb_ff);
      end
   end

   // reconstruction datapath
   always_comb begin
      slot     = cnt_ff[bpp_sel];
      a_byte   = left_ff[slot];
      c_byte   = ul_ff[slot];
      b_byte   = first_ff ? DW'(0) : ram_rd_data;
      x_addr   = AW'(col_ff - CW'(1));
      row_last = CMPW'(col_ff) >= rb_eff;
      avg_sum  = {1'b0, a_byte} + {1'b0, b_byte};
      case (kind_ff)
         psu_pkg::FILT_SUB:   pred = a_byte;
         psu_pkg::FILT_UP:    pred = b_byte;
         psu_pkg::FILT_AVG:   pred = avg_sum[DW:1];
         psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pred(a_byte, b_byte, c_byte);
         default:             pred = DW'(0);
      endcase
      val = req_chan.data_byte + pred;
   end

   // line RAM control: write the rebuilt byte, prefetch the next column
   always_comb begin
      ram_wr_en   = accept && !col_start;
      ram_rd_en   = accept && (col_start || !row_last);
      ram_rd_addr = col_start ? AW'(0) : AW'(col_ff);
   end

   // state next values
   always_comb begin
      bpp_in   = bpp_ff;
      rb_in    = rb_ff;
      col_in   = col_ff;
      first_in = first_ff;
      kind_in  = kind_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      ul_in    = ul_ff;
      if (csr_we) begin
         unique case (csr_index)
            psu_pkg::CSR_BYTES_PER_PIXEL: bpp_in = csr_wdata[psu_pkg::BPP_W-1:0];
            psu_pkg::CSR_ROW_BYTES:       rb_in  = csr_wdata[psu_pkg::ROW_BYTES_W-1:0];
            default: ;
         endcase
      end
      if (accept) begin
         if (col_start) begin
            col_in = CW'(1);
            if (req_chan.frame_start) begin
               first_in = 1'b1;
            end
            if (req_chan.data_byte > psu_pkg::FILT_MAX_CODE) begin
               kind_in = psu_pkg::FILT_NONE;
            end else begin
               kind_in = psu_pkg::filter_kind_type'(req_chan.data_byte[2:0]);
            end
            for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
               cnt_in[i]  = SW'(0);
               left_in[i] = DW'(0);
               ul_in[i]   = DW'(0);
            end
         end else begin
            left_in[slot] = val;
            ul_in[slot]   = b_byte;
            for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
               cnt_in[i] = (cnt_ff[i] == SW'(i)) ? SW'(0) : cnt_ff[i] + SW'(1);
            end
            if (row_last) begin
               col_in   = CW'(0);
               first_in = 1'b0;
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (accept) begin
         if (!col_start) begin
            rsp_valid_in = 1'b1;
            rsp_pixel_in = val;
            rsp_end_in   = row_last;
            rsp_bad_in   = 1'b0;
         end else if (req_chan.data_byte > psu_pkg::FILT_MAX_CODE) begin
            rsp_valid_in = 1'b1;
            rsp_pixel_in = DW'(0);
            rsp_end_in   = 1'b0;
            rsp_bad_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= psu_pkg::BPP_W'(1);
         rb_ff        <= psu_pkg::ROW_BYTES_W'(1);
         col_ff       <= CW'(0);
         first_ff     <= 1'b1;
         kind_ff      <= psu_pkg::FILT_NONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
            cnt_ff[i]  <= SW'(0);
            left_ff[i] <= DW'(0);
            ul_ff[i]   <= DW'(0);
         end
      end else begin
         bpp_ff       <= bpp_in;
         rb_ff        <= rb_in;
         col_ff       <= col_in;
         first_ff     <= first_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         ul_ff        <= ul_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pixel_byte = rsp_pixel_ff;
   assign rsp_chan.row_end    = rsp_end_ff;
   assign rsp_chan.bad_filter = rsp_bad_ff;

   `ASSERT_NXT(a_data_beat_gives_rsp, clock, reset, accept && !col_start, rsp_valid_ff)
   `ASSERT_NXT(a_row_end_rewinds, clock, reset,
               accept && !col_start && row_last, col_ff == CW'(0))
   `ASSERT_IMP(a_ram_no_same_entry, clock, reset, ram_wr_en && ram_rd_en,
               x_addr != ram_rd_addr)
   `ASSERT_IMP(a_first_row_leaves_at_end, clock, reset, $fell(first_ff),
               $past(accept && !col_start && row_last))

endmodule

`default_nettype wire

// ===== hw/rtl/psu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
